>>> rtl/core/flt_pkg.sv
// Shared types and constants of the bucketed flow learn table.
// No dependencies; imported by every module of the block but flt_ram.
`default_nettype none
package flt_pkg;

  localparam int NUM_BUCKETS      = 2048;
  localparam int SLOTS_PER_BUCKET = 16;
  localparam int KEY_W            = 32;
  localparam int BKT_W            = 11;
  localparam int SLOT_W           = 4;
  localparam int ADDR_W           = BKT_W + SLOT_W;
  localparam int CFG_W            = 12;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 12'h400;
  localparam logic [CFG_W-1:0] FAST_LIMIT_RST   = 12'h600;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_MAX = 12'h800;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUCKET_COUNT = 2'd0,
    REG_FAST_LIMIT   = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OUT_NEW    = 2'd0,
    OUT_HIT    = 2'd1,
    OUT_MISS   = 2'd2,
    OUT_BYPASS = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN
  } back_state_t;

  typedef struct packed {
    logic             to_cpu;
    logic             fast;
    logic [BKT_W-1:0] bucket;
    logic [KEY_W-1:0] src;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/core/flt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module flt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/flt_front.sv
// Front end: accepts packets, computes bucket = dest mod count two bits a
// cycle, tags the fast region and pushes a job. Depends on flt_pkg.
`default_nettype none
module flt_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic                         send_to_cpu,
  input  wire logic [flt_pkg::KEY_W-1:0]    dest_ip,
  input  wire logic [flt_pkg::KEY_W-1:0]    src_ip,
  input  wire logic [flt_pkg::CFG_W-1:0]    bucket_count,
  input  wire logic [flt_pkg::CFG_W-1:0]    fast_limit,
  input  wire logic                         q_full,
  output logic                              q_push,
  output flt_pkg::job_t                     q_job,
  output logic                              busy
);
  import flt_pkg::*;

  front_state_t     state_r, state_nxt;
  logic [KEY_W-1:0] dv_r, dv_nxt;
  logic [BKT_W-1:0] rem_r, rem_nxt;
  logic [CFG_W-1:0] div_r, div_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  job_t             job_r, job_nxt;
  logic [CFG_W-1:0] r1, r2, eff_count;

  always_comb begin
    if (bucket_count == '0) begin
      eff_count = CFG_W'(1);
    end else if (bucket_count > BUCKET_COUNT_MAX) begin
      eff_count = BUCKET_COUNT_MAX;
    end else begin
      eff_count = bucket_count;
    end
  end

  // Two restoring steps per cycle
  always_comb begin
    r1 = {rem_r, dv_r[KEY_W-1]};
    if (r1 >= div_r) begin
      r1 = r1 - div_r;
    end
    r2 = {r1[BKT_W-1:0], dv_r[KEY_W-2]};
    if (r2 >= div_r) begin
      r2 = r2 - div_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dv_nxt    = dv_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    job_nxt   = job_r;
    q_push    = 1'b0;
    unique case (state_r)
      FR_IDLE: begin
        if (accept) begin
          job_nxt.to_cpu = send_to_cpu;
          job_nxt.fast   = 1'b0;
          job_nxt.bucket = '0;
          job_nxt.src    = src_ip;
          dv_nxt         = dest_ip;
          rem_nxt        = '0;
          div_nxt        = eff_count;
          cnt_nxt        = '0;
          state_nxt      = send_to_cpu ? FR_PUSH : FR_DIV;
        end
      end
      FR_DIV: begin
        rem_nxt = r2[BKT_W-1:0];
        dv_nxt  = {dv_r[KEY_W-3:0], 2'b00};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'hf) begin
          job_nxt.bucket = r2[BKT_W-1:0];
          job_nxt.fast   = {1'b0, r2[BKT_W-1:0]} < fast_limit;
          state_nxt      = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dv_r  <= dv_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    job_r <= job_nxt;
  end

  assign q_job = job_r;
  assign busy  = state_r != FR_IDLE;

endmodule
`default_nettype wire

>>> rtl/core/flt_queue.sv
// Two-entry job queue between front and back end. Depends on flt_pkg.
`default_nettype none
module flt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire flt_pkg::job_t push_job,
  input  wire logic          pop,
  output flt_pkg::job_t      pop_job,
  output logic               empty,
  output logic               full
);
  import flt_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  assign pop_job = ent_r[rp_r];
  assign empty   = cnt_r == 2'd0;
  assign full    = cnt_r == 2'd2;

endmodule
`default_nettype wire

>>> rtl/core/flt_back.sv
// Back end: clears the key store after reset, then scans one bucket per
// table job with pipelined reads and writes the key on a fresh slot.
// Depends on flt_pkg and flt_ram.
`default_nettype none
module flt_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  wire flt_pkg::job_t              q_job,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            out_valid,
  output logic                            out_to_cpu,
  output logic                            out_in_fast_region,
  output logic [flt_pkg::BKT_W-1:0]       out_bucket_index,
  output logic [1:0]                      out_first_outcome,
  output logic [1:0]                      out_second_outcome,
  output logic [flt_pkg::SLOT_W-1:0]      out_slot_index
);
  import flt_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [SLOT_W:0]   iss_r, iss_nxt;
  logic              rd_valid_r;
  logic [SLOT_W-1:0] rd_slot_r;
  job_t              job_r, job_nxt;

  logic              vld_r, vld_nxt;
  logic              cpu_r, cpu_nxt;
  logic              fast_r, fast_nxt;
  logic [BKT_W-1:0]  bkt_r, bkt_nxt;
  outcome_t          first_r, first_nxt, second_r, second_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic              issue, decide;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [KEY_W-1:0]  ram_wdata, ram_rdata;

  flt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NUM_BUCKETS * SLOTS_PER_BUCKET)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    iss_nxt    = iss_r;
    job_nxt    = job_r;
    vld_nxt    = 1'b0;
    cpu_nxt    = cpu_r;
    fast_nxt   = fast_r;
    bkt_nxt    = bkt_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    slot_nxt   = slot_r;
    q_pop      = 1'b0;
    issue      = 1'b0;
    decide     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = {job_r.bucket, rd_slot_r};
    ram_wdata  = job_r.src;
    ram_raddr  = {job_r.bucket, iss_r[SLOT_W-1:0]};
    unique case (state_r)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          iss_nxt = '0;
          if (q_job.to_cpu) begin
            vld_nxt    = 1'b1;
            cpu_nxt    = 1'b1;
            fast_nxt   = 1'b0;
            bkt_nxt    = '0;
            first_nxt  = OUT_BYPASS;
            second_nxt = OUT_BYPASS;
            slot_nxt   = '0;
          end else begin
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        cpu_nxt  = 1'b0;
        fast_nxt = job_r.fast;
        bkt_nxt  = job_r.bucket;
        slot_nxt = rd_slot_r;
        if (rd_valid_r) begin
          if (ram_rdata == '0) begin
            // Fresh slot: a zero key leaves it empty, so the next pass fills it again
            decide     = 1'b1;
            ram_we     = 1'b1;
            first_nxt  = OUT_NEW;
            second_nxt = (job_r.src == '0) ? OUT_NEW : OUT_HIT;
          end else if (ram_rdata == job_r.src) begin
            decide     = 1'b1;
            first_nxt  = OUT_HIT;
            second_nxt = OUT_HIT;
          end else if (rd_slot_r == SLOT_W'(SLOTS_PER_BUCKET - 1)) begin
            decide     = 1'b1;
            first_nxt  = OUT_MISS;
            second_nxt = OUT_MISS;
            slot_nxt   = '0;
          end
        end
        if (decide) begin
          vld_nxt   = 1'b1;
          state_nxt = BK_IDLE;
        end else if (!iss_r[SLOT_W]) begin
          issue   = 1'b1;
          iss_nxt = iss_r + 1'b1;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_r      <= '0;
      rd_valid_r <= 1'b0;
      vld_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      rd_valid_r <= issue;
      vld_r      <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r     <= iss_nxt;
    rd_slot_r <= iss_r[SLOT_W-1:0];
    job_r     <= job_nxt;
    cpu_r     <= cpu_nxt;
    fast_r    <= fast_nxt;
    bkt_r     <= bkt_nxt;
    first_r   <= first_nxt;
    second_r  <= second_nxt;
    slot_r    <= slot_nxt;
  end

  assign clearing           = state_r == BK_CLEAR;
  assign out_valid          = vld_r;
  assign out_to_cpu         = cpu_r;
  assign out_in_fast_region = fast_r;
  assign out_bucket_index   = bkt_r;
  assign out_first_outcome  = first_r;
  assign out_second_outcome = second_r;
  assign out_slot_index     = slot_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == BK_IDLE)
    else $error("job popped while back end busy");

  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == BK_SCAN) |-> ram_rdata == '0)
    else $error("key written over an occupied slot");

  a_table_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !cpu_r) |-> first_r != OUT_BYPASS)
    else $error("table result marked as bypassed");

endmodule
`default_nettype wire

>>> rtl/core/bucketed_flow_learn_table.sv
// Bucketed flow learn table, top level: configuration registers, front
// end, job queue and back end. Depends on flt_pkg and all flt_ modules.
//
// Usage: raise start with in_send_to_cpu, in_dest_ip and in_src_ip; the
// packet is taken at a rising edge where start is high and busy is low.
// Each packet yields one result, shown for a single cycle with out_valid
// high; the receiver cannot stall, so results are never held.
// A to-CPU packet skips the division and the table and passes through the
// queue straight to the result. Any other packet runs through the
// two-bits-per-cycle remainder unit and enters the queue, then the bucket
// scan issues one key read a cycle from the single read port until it
// decides.
// The front end takes no new packet until its job is pushed, limited by
// the remainder unit; the back end overlaps through the two-entry queue.
// Configuration: cfg_we, cfg_index, cfg_wdata write a register at once;
// write only while the block is idle.
// After reset the key store is cleared one entry a cycle, all 32768 entries,
// during which busy stays high.
`default_nettype none
module bucketed_flow_learn_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_send_to_cpu,
  input  wire logic [flt_pkg::KEY_W-1:0]      in_dest_ip,
  input  wire logic [flt_pkg::KEY_W-1:0]      in_src_ip,
  output logic                                out_valid,
  output logic                                out_to_cpu,
  output logic                                out_in_fast_region,
  output logic [flt_pkg::BKT_W-1:0]           out_bucket_index,
  output logic [1:0]                          out_first_outcome,
  output logic [1:0]                          out_second_outcome,
  output logic [flt_pkg::SLOT_W-1:0]          out_slot_index,
  input  wire logic                           cfg_we,
  input  wire logic [flt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [flt_pkg::CFG_W-1:0]      cfg_wdata
);
  import flt_pkg::*;

  logic [CFG_W-1:0] bucket_count_r, fast_limit_r;
  logic             front_busy, clearing, accept;
  logic             q_push, q_pop, q_empty, q_full;
  job_t             push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RST;
      fast_limit_r   <= FAST_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
        REG_FAST_LIMIT:   fast_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  flt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .send_to_cpu  (in_send_to_cpu),
    .dest_ip      (in_dest_ip),
    .src_ip       (in_src_ip),
    .bucket_count (bucket_count_r),
    .fast_limit   (fast_limit_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job),
    .busy         (front_busy)
  );

  flt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  flt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_job              (pop_job),
    .q_pop              (q_pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_to_cpu         (out_to_cpu),
    .out_in_fast_region (out_in_fast_region),
    .out_bucket_index   (out_bucket_index),
    .out_first_outcome  (out_first_outcome),
    .out_second_outcome (out_second_outcome),
    .out_slot_index     (out_slot_index)
  );

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for bucketed_flow_learn_table: directed table, then random packets.
// Predicts every result with a local bucket store model; depends on flt_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import flt_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_send_to_cpu = 1'b0;
  logic [KEY_W-1:0] in_dest_ip = '0;
  logic [KEY_W-1:0] in_src_ip = '0;
  logic out_valid, out_to_cpu, out_in_fast_region;
  logic [BKT_W-1:0] out_bucket_index;
  logic [1:0] out_first_outcome, out_second_outcome;
  logic [SLOT_W-1:0] out_slot_index;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  typedef struct packed {
    logic to_cpu;
    logic fast;
    logic [BKT_W-1:0] bucket;
    outcome_t first;
    outcome_t second;
    logic [SLOT_W-1:0] slot;
  } verdict_t;

  typedef struct {
    logic cpu;
    logic [31:0] dst;
    logic [31:0] src;
    logic known;
    verdict_t want;
  } stim_row_t;

  logic [KEY_W-1:0] flow_keys [NUM_BUCKETS*SLOTS_PER_BUCKET];
  logic [CFG_W-1:0] model_count, model_fast;
  verdict_t pending_verdicts[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  stim_row_t rows[$];

  bucketed_flow_learn_table dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic outcome_t probe_bucket(int base, logic [31:0] key, ref logic [3:0] slot);
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (flow_keys[base+s] == 0) begin
        flow_keys[base+s] = key;
        slot = SLOT_W'(s);
        return OUT_NEW;
      end
      if (flow_keys[base+s] == key) begin
        slot = SLOT_W'(s);
        return OUT_HIT;
      end
    end
    slot = '0;
    return OUT_MISS;
  endfunction

  function automatic verdict_t learn_flow(logic cpu, logic [31:0] dst, logic [31:0] src);
    verdict_t v;
    int cnt;
    int bkt;
    logic [3:0] slot;
    v = '0;
    if (cpu) begin
      v.to_cpu = 1'b1;
      v.first = OUT_BYPASS;
      v.second = OUT_BYPASS;
      return v;
    end
    cnt = int'(model_count);
    if (cnt == 0) cnt = 1;
    if (cnt > NUM_BUCKETS) cnt = NUM_BUCKETS;
    bkt = dst % cnt;
    v.fast = (bkt < int'(model_fast));
    v.bucket = BKT_W'(bkt);
    v.first = probe_bucket(bkt * SLOTS_PER_BUCKET, src, slot);
    v.second = probe_bucket(bkt * SLOTS_PER_BUCKET, src, slot);
    v.slot = slot;
    return v;
  endfunction

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = pending_verdicts.pop_front();
        if (out_to_cpu !== e.to_cpu) begin
          $error("to_cpu exp %0d got %0d", e.to_cpu, out_to_cpu); errors++;
        end
        if (out_in_fast_region !== e.fast) begin
          $error("in_fast_region exp %0d got %0d", e.fast, out_in_fast_region); errors++;
        end
        if (out_bucket_index !== e.bucket) begin
          $error("bucket_index exp %0d got %0d", e.bucket, out_bucket_index); errors++;
        end
        if (out_first_outcome !== e.first) begin
          $error("first_outcome exp %0d got %0d", e.first, out_first_outcome); errors++;
        end
        if (out_second_outcome !== e.second) begin
          $error("second_outcome exp %0d got %0d", e.second, out_second_outcome); errors++;
        end
        if (out_slot_index !== e.slot) begin
          $error("slot_index exp %0d got %0d", e.slot, out_slot_index); errors++;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BUCKET_COUNT) model_count = val;
    else model_fast = val;
    @(posedge clk);
  endtask

  // Hold until every result is in, then let the back end settle.
  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_packet(logic cpu, logic [31:0] dst, logic [31:0] src,
                             logic known, verdict_t want);
    verdict_t v;
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_send_to_cpu <= cpu;
    in_dest_ip <= dst;
    in_src_ip <= src;
    @(posedge clk);
    while (busy) @(posedge clk);
    v = learn_flow(cpu, dst, src);
    if (known && v !== want) begin
      $error("directed row prediction mismatch exp %h got %h", want, v);
      errors++;
    end
    pending_verdicts.push_back(v);
  endtask

  function automatic verdict_t mk(logic c, logic f, int b, outcome_t a, outcome_t s, int sl);
    verdict_t v;
    v.to_cpu = c; v.fast = f; v.bucket = BKT_W'(b); v.first = a; v.second = s;
    v.slot = SLOT_W'(sl);
    return v;
  endfunction

  task automatic add_row(logic cpu, logic [31:0] dst, logic [31:0] src,
                         logic known, verdict_t want);
    stim_row_t r;
    r.cpu = cpu; r.dst = dst; r.src = src; r.known = known; r.want = want;
    rows.push_back(r);
  endtask

  task automatic random_phase(int n, int idle);
    logic [31:0] pool [8];
    send_idle_pct = idle;
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    for (int i = 0; i < n; i++) begin
      logic [31:0] d, s;
      d = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(40, 0);
      s = ($urandom_range(2, 0) == 0) ? $urandom() : pool[$urandom_range(7, 0)];
      if ($urandom_range(30, 0) == 0) s = 0;
      send_packet($urandom_range(9, 0) == 0, d, s, 1'b0, '0);
    end
    drain();
  endtask

  initial begin
    model_count = BUCKET_COUNT_RST;
    model_fast = FAST_LIMIT_RST;
    foreach (flow_keys[i]) flow_keys[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; predictions checked against typed values where obvious.
    add_row(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            mk(1'b1, 1'b0, 0, OUT_BYPASS, OUT_BYPASS, 0));
    add_row(1'b0, 0, 32'hFFFF_FFFF, 1'b1, mk(1'b0, 1'b1, 0, OUT_NEW, OUT_HIT, 0));
    add_row(1'b0, 32'hFFFF_FFFF, 32'h1, 1'b1, mk(1'b0, 1'b1, 1023, OUT_NEW, OUT_HIT, 0));
    add_row(1'b0, 0, 0, 1'b1, mk(1'b0, 1'b1, 0, OUT_NEW, OUT_NEW, 1));
    add_row(1'b0, 1024, 32'hFFFF_FFFF, 1'b1, mk(1'b0, 1'b1, 0, OUT_HIT, OUT_HIT, 0));
    add_row(1'b0, 5, 0, 1'b1, mk(1'b0, 1'b1, 5, OUT_NEW, OUT_NEW, 0));
    for (int i = 1; i <= 16; i++) add_row(1'b0, 7, 32'h100 + i, 1'b0, '0);
    add_row(1'b0, 7, 32'hDEAD_BEEF, 1'b1, mk(1'b0, 1'b1, 7, OUT_MISS, OUT_MISS, 0));
    foreach (rows[i]) send_packet(rows[i].cpu, rows[i].dst, rows[i].src, rows[i].known,
                                  rows[i].want);
    drain();

    write_reg(REG_BUCKET_COUNT, 12'd0);
    write_reg(REG_FAST_LIMIT, 12'd0);
    random_phase(150, 0);
    write_reg(REG_BUCKET_COUNT, 12'hFFF);
    write_reg(REG_FAST_LIMIT, 12'hFFF);
    random_phase(250, 76);
    write_reg(REG_BUCKET_COUNT, 12'd2048);
    write_reg(REG_FAST_LIMIT, 12'd2048);
    random_phase(200, 13);
    write_reg(REG_BUCKET_COUNT, 12'd3);
    write_reg(REG_FAST_LIMIT, 12'd1);
    random_phase(250, 0);
    write_reg(REG_BUCKET_COUNT, 12'd37);
    write_reg(REG_FAST_LIMIT, 12'd20);
    random_phase(180, 40);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
